// ----- hdl/ghvm_pkg.sv -----
package ghvm_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int CELL_SHIFT   = 5;
	localparam int COORD_BITS   = 24;

	localparam int IDX_W    = $clog2(MAX_VERTICES);
	localparam int CNT_W    = $clog2(MAX_VERTICES + 1);
	localparam int OUT_IW   = 10;
	localparam int RAD_W    = 20;
	localparam int CELL_W   = COORD_BITS - CELL_SHIFT;
	localparam int DIFF_W   = CELL_SHIFT + 1;
	localparam int SQ_W     = 2 * DIFF_W + 1;
	localparam int CMP_W    = (SQ_W > RAD_W) ? SQ_W : RAD_W;
	localparam int RANK_W   = 4;

	localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(369);
	localparam logic ACT_FIND  = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	typedef struct packed {
		logic                         action;
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
	} point_item_t;

	typedef struct packed {
		logic [OUT_IW-1:0] vertex_index;
		logic              was_merged;
		logic              store_full;
	} result_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} ghvm_state_t;

endpackage

// ----- hdl/grid_hash_vertex_merge_unit.sv -----
// Grid hash vertex merge unit.
// The point channel (point_valid, point_stall, point) carries one item per
// request: either a find-or-add of a 2-D point or a clear of the vertex store.
// The result channel (result_valid, result_stall, result) returns exactly one
// item per request: the matched or newly added vertex index and flags.
// cfg_we and cfg_data write the squared merge radius; the user must write it
// only while the unit is idle, as the unit itself does not enforce this.
// A clear item or a point with an empty store goes from idle straight to its
// final step. Any other point searches all N stored vertices: the store
// memory is read one vertex per cycle and a single distance and cell compare
// unit checks each vertex as it comes out. A new item is taken only when the
// previous one has left the search.
// The result sits in an output register; while the receiver stalls, the unit
// may accept and search the next item, and it holds in its final step until
// the output register is free.
// Reset empties the store (the vertex count goes to zero, no memory pass is
// needed) and sets the merge radius to 369.
module grid_hash_vertex_merge_unit
	import ghvm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              point_valid,
	output logic              point_stall,
	input  point_item_t       point,
	output logic              result_valid,
	input  logic              result_stall,
	output result_item_t      result,
	input  logic              cfg_we,
	input  logic [RAD_W-1:0]  cfg_data
);

	logic [2*COORD_BITS-1:0] mem [MAX_VERTICES];

	ghvm_state_t state_q, state_d;

	logic [RAD_W-1:0]             radius_q;
	logic [CNT_W-1:0]             count_q;
	logic [IDX_W-1:0]             idx_q;
	logic signed [COORD_BITS-1:0] px_q, py_q;
	logic                         clear_q;
	logic                         best_vld_q;
	logic [IDX_W-1:0]             best_idx_q;
	logic [RANK_W-1:0]            best_rank_q;

	logic [2*COORD_BITS-1:0] rd_data_s1;
	logic                    rd_vld_s1;
	logic [IDX_W-1:0]        idx_s1;

	logic accept, last_issue, load_result, do_append;

	logic signed [COORD_BITS-1:0] sx, sy;
	logic signed [CELL_W:0]       dcx, dcy;
	logic signed [COORD_BITS:0]   dfx, dfy;
	logic [COORD_BITS:0]          afx, afy;
	logic [DIFF_W-1:0]            ex, ey;
	logic [SQ_W-1:0]              sq_dist;
	logic [1:0]                   rx, ry;
	logic                         in_x, in_y;
	logic [RANK_W-1:0]            rank;
	logic                         hit;
	logic [IDX_W+OUT_IW-1:0]      idx_wide;
	logic [IDX_W-1:0]             res_idx;

	assign accept     = point_valid && !point_stall;
	assign last_issue = ({1'b0, idx_q} == (count_q - CNT_W'(1)));

	always_comb begin
		state_d     = state_q;
		point_stall = 1'b1;
		load_result = 1'b0;
		do_append   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				point_stall = 1'b0;
				if (point_valid) begin
					if (point.action == ACT_CLEAR || count_q == '0) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!result_valid || !result_stall) begin
					load_result = 1'b1;
					do_append   = !clear_q && !best_vld_q &&
						(count_q != CNT_W'(MAX_VERTICES));
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign sx  = rd_data_s1[2*COORD_BITS-1:COORD_BITS];
	assign sy  = rd_data_s1[COORD_BITS-1:0];
	assign dcx = {sx[COORD_BITS-1], sx[COORD_BITS-1:CELL_SHIFT]} -
		{px_q[COORD_BITS-1], px_q[COORD_BITS-1:CELL_SHIFT]};
	assign dcy = {sy[COORD_BITS-1], sy[COORD_BITS-1:CELL_SHIFT]} -
		{py_q[COORD_BITS-1], py_q[COORD_BITS-1:CELL_SHIFT]};
	assign dfx = {sx[COORD_BITS-1], sx} - {px_q[COORD_BITS-1], px_q};
	assign dfy = {sy[COORD_BITS-1], sy} - {py_q[COORD_BITS-1], py_q};
	assign afx = dfx[COORD_BITS] ? (COORD_BITS+1)'(-dfx) : dfx;
	assign afy = dfy[COORD_BITS] ? (COORD_BITS+1)'(-dfy) : dfy;
	assign ex  = afx[DIFF_W-1:0];
	assign ey  = afy[DIFF_W-1:0];
	assign sq_dist = SQ_W'(ex) * SQ_W'(ex) + SQ_W'(ey) * SQ_W'(ey);

	always_comb begin
		in_x = 1'b1;
		in_y = 1'b1;
		rx   = 2'd1;
		ry   = 2'd1;
		if (dcx == -(CELL_W+1)'(1)) begin
			rx = 2'd0;
		end else if (dcx == (CELL_W+1)'(1)) begin
			rx = 2'd2;
		end else if (dcx != '0) begin
			in_x = 1'b0;
		end
		if (dcy == -(CELL_W+1)'(1)) begin
			ry = 2'd0;
		end else if (dcy == (CELL_W+1)'(1)) begin
			ry = 2'd2;
		end else if (dcy != '0) begin
			in_y = 1'b0;
		end
	end

	assign rank = RANK_W'({2'b00, rx} * 4'd3) + {2'b00, ry};
	assign hit  = rd_vld_s1 && in_x && in_y &&
		(CMP_W'(sq_dist) <= CMP_W'(radius_q)) &&
		(!best_vld_q || rank < best_rank_q);

	always_ff @(posedge clk) begin
		rd_data_s1 <= mem[idx_q];
		idx_s1     <= idx_q;
		if (do_append) begin
			mem[count_q[IDX_W-1:0]] <= {px_q, py_q};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q    <= point.point_x;
			py_q    <= point.point_y;
			clear_q <= (point.action == ACT_CLEAR);
		end
		if (hit) begin
			best_idx_q  <= idx_s1;
			best_rank_q <= rank;
		end
	end

	assign res_idx  = best_vld_q ? best_idx_q : count_q[IDX_W-1:0];
	assign idx_wide = {{OUT_IW{1'b0}}, res_idx};

	always_ff @(posedge clk) begin
		if (load_result) begin
			if (clear_q) begin
				result <= '0;
			end else if (best_vld_q) begin
				result.vertex_index <= idx_wide[OUT_IW-1:0];
				result.was_merged   <= 1'b1;
				result.store_full   <= 1'b0;
			end else if (count_q == CNT_W'(MAX_VERTICES)) begin
				result.vertex_index <= '0;
				result.was_merged   <= 1'b0;
				result.store_full   <= 1'b1;
			end else begin
				result.vertex_index <= idx_wide[OUT_IW-1:0];
				result.was_merged   <= 1'b0;
				result.store_full   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q     <= RADIUS_RESET;
			count_q      <= '0;
			idx_q        <= '0;
			best_vld_q   <= 1'b0;
			rd_vld_s1    <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				radius_q <= cfg_data;
			end
			rd_vld_s1 <= (state_q == ST_SCAN);
			if (accept) begin
				idx_q      <= '0;
				best_vld_q <= 1'b0;
				if (point.action == ACT_CLEAR) begin
					count_q <= '0;
				end
			end else if (state_q == ST_SCAN && !last_issue) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (hit) begin
				best_vld_q <= 1'b1;
			end
			if (do_append) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (load_result) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

endmodule

// ----- tb/tb.sv -----
module tb;
	import ghvm_pkg::*;

	logic clk;
	logic arst_n;
	logic point_valid;
	logic point_stall;
	point_item_t point;
	logic result_valid;
	logic result_stall;
	result_item_t result;
	logic cfg_we;
	logic [RAD_W-1:0] cfg_data;

	bit calm;
	int items_sent;

	grid_hash_vertex_merge_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point(point),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	// Tracks the vertex store and the merge radius, and holds the results still owed.
	class weld_tracker;
		logic signed [COORD_BITS-1:0] xs [MAX_VERTICES];
		logic signed [COORD_BITS-1:0] ys [MAX_VERTICES];
		int count;
		logic [RAD_W-1:0] radius;
		result_item_t owed_results [$];
		int errors;

		function new();
			count = 0;
			radius = RADIUS_RESET;
			errors = 0;
		endfunction

		function int owed();
			return owed_results.size();
		endfunction

		function void take_point(point_item_t p);
			result_item_t r;
			logic signed [COORD_BITS-1:0] px;
			logic signed [COORD_BITS-1:0] py;
			int cx, cy, dcx, dcy, rank, best_rank, best_idx;
			longint ex, ey;
			r = '0;
			px = p.point_x;
			py = p.point_y;
			if (p.action == ACT_CLEAR) begin
				count = 0;
			end else begin
				cx = int'(px) >>> CELL_SHIFT;
				cy = int'(py) >>> CELL_SHIFT;
				best_rank = 9;
				best_idx = 0;
				for (int i = 0; i < count; i++) begin
					dcx = (int'(xs[i]) >>> CELL_SHIFT) - cx;
					dcy = (int'(ys[i]) >>> CELL_SHIFT) - cy;
					if (dcx >= -1 && dcx <= 1 && dcy >= -1 && dcy <= 1) begin
						ex = longint'(xs[i]) - longint'(px);
						ey = longint'(ys[i]) - longint'(py);
						rank = (dcx + 1) * 3 + dcy + 1;
						if (ex * ex + ey * ey <= longint'(radius) && rank < best_rank) begin
							best_rank = rank;
							best_idx = i;
						end
					end
				end
				if (best_rank < 9) begin
					r.vertex_index = OUT_IW'(best_idx);
					r.was_merged = 1'b1;
				end else if (count >= MAX_VERTICES) begin
					r.store_full = 1'b1;
				end else begin
					xs[count] = px;
					ys[count] = py;
					r.vertex_index = OUT_IW'(count);
					count++;
				end
			end
			owed_results.push_back(r);
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= 40)
					$display("%0t: %s expected %0d got %0d", $time, field, want, got);
			end
		endfunction

		function void match_result(result_item_t got);
			result_item_t want;
			if (owed_results.size() == 0) begin
				errors++;
				if (errors <= 40)
					$display("%0t: result %h arrived with none expected", $time, got);
				return;
			end
			want = owed_results.pop_front();
			compare("vertex_index", want.vertex_index, got.vertex_index);
			compare("was_merged", want.was_merged, got.was_merged);
			compare("store_full", want.store_full, got.store_full);
		endfunction
	endclass

	weld_tracker tracker = new();

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic int draw_gap();
		return calm ? 0 : int'($urandom_range(0, 8));
	endfunction

	task automatic send(point_item_t it);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			point_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		point_valid <= 1'b1;
		point <= it;
		do @(posedge clk); while (point_stall);
		items_sent++;
	endtask

	task automatic put(int x, int y);
		point_item_t it;
		it.action = ACT_FIND;
		it.point_x = COORD_BITS'(x);
		it.point_y = COORD_BITS'(y);
		send(it);
	endtask

	task automatic put_clear();
		point_item_t it;
		it.action = ACT_CLEAR;
		it.point_x = COORD_BITS'($urandom);
		it.point_y = COORD_BITS'($urandom);
		send(it);
	endtask

	task automatic set_radius(logic [RAD_W-1:0] v);
		point_valid <= 1'b0;
		@(posedge clk);
		while (tracker.owed() != 0) @(posedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.radius = v;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				tracker.match_result(result);
			if (point_valid && !point_stall)
				tracker.take_point(point);
		end
	end

	initial begin
		int hold;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = draw_gap();
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	initial begin
		#50000000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int phase, n, spread, k, j, ox, oy, cx0, cy0;
		int fx [MAX_VERTICES];
		int fy [MAX_VERTICES];
		logic [RAD_W-1:0] rad;
		point_item_t it;
		point_item_t seen [$];

		arst_n = 1'b0;
		point_valid = 1'b0;
		point = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		calm = 1'b0;
		items_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put_clear();
		put(0, 0);
		put(12, 15);
		put(12, 16);
		put(-1, -1);
		put(-8388608, -8388608);
		put(8388607, 8388607);
		put(-8388598, -8388608);

		// A huge radius still only searches the 3x3 cells, and the cell range does not wrap.
		set_radius(20'hFFFFF);
		put(100, 0);
		put(8388580, 8388580);
		put_clear();
		put(-8388608, 0);
		put(8388607, 0);

		set_radius('0);
		put_clear();
		put(5, -7);
		put(5, -7);
		put(5, -6);

		// The earlier neighbor cell wins over the lower index.
		set_radius(RAD_W'(4000));
		put_clear();
		put(40, 0);
		put(-5, 0);
		put(10, 0);

		items_sent = 0;
		phase = 0;
		while (items_sent < 2000) begin
			if (phase == 2) begin
				calm = 1'b0;
				set_radius(RADIUS_RESET);
				put_clear();
				ox = int'($urandom_range(0, 400000)) - 200000;
				oy = int'($urandom_range(0, 400000)) - 200000;
				for (int i = 0; i < MAX_VERTICES; i++) begin
					fx[i] = ox + (i % 32) * 40 + int'($urandom_range(0, 6)) - 3;
					fy[i] = oy + (i / 32) * 40 + int'($urandom_range(0, 6)) - 3;
					put(fx[i], fy[i]);
				end
				for (int i = 0; i < 6; i++) begin
					j = $urandom_range(0, MAX_VERTICES - 1);
					put(fx[j], fy[j]);
					put(ox - 3000, oy - 3000 - i * 100);
				end
				put_clear();
			end else begin
				calm = ($urandom_range(0, 3) == 0);
				case ($urandom_range(0, 5))
					0: rad = '0;
					1: rad = RADIUS_RESET;
					2: rad = '1;
					3: rad = RAD_W'($urandom_range(1, 600));
					4: rad = RAD_W'($urandom_range(600, 9000));
					default: rad = RAD_W'($urandom);
				endcase
				set_radius(rad);
				n = $urandom_range(10, 40);
				spread = $urandom_range(4, 96);
				cx0 = int'($urandom);
				cy0 = int'($urandom);
				seen.delete();
				put_clear();
				repeat (n) begin
					k = $urandom_range(0, 99);
					if (k < 4) begin
						put_clear();
					end else begin
						it.action = ACT_FIND;
						if (k < 12) begin
							it.point_x = COORD_BITS'($urandom);
							it.point_y = COORD_BITS'($urandom);
						end else if (k < 25 && seen.size() > 0) begin
							it = seen[$urandom_range(0, seen.size() - 1)];
						end else begin
							it.point_x = COORD_BITS'(cx0 + int'($urandom_range(0, 2 * spread)) - spread);
							it.point_y = COORD_BITS'(cy0 + int'($urandom_range(0, 2 * spread)) - spread);
						end
						seen.push_back(it);
						send(it);
					end
				end
			end
			phase++;
		end

		point_valid <= 1'b0;
		@(posedge clk);
		while (tracker.owed() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (tracker.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
